### rtl/lkvc_pkg.sv
// lkvc_pkg: shared constants for the lru key-value cache
// default sizes, fixed port widths and the capacity reset value
// no dependencies
package lkvc_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_VALUE_BITS = 32;

    // capacity register word and read value port are fixed in width
    localparam int CAP_BITS  = 5;
    localparam int READ_BITS = 32;
    localparam int CAP_RESET = 16;

endpackage

### rtl/lkvc_entry_mem.sv
// lkvc_entry_mem: single-port-write, single-port-read entry memory
// read data registered, updated only when re is set
// no dependencies
module lkvc_entry_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 52,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value store with lru replacement
// depends on lkvc_pkg and lkvc_entry_mem
//
//   channel   signals                               handshake
//   --------  ------------------------------------  -----------------------------
//   command   kind, lookup_key, write_value         taken when start && !busy
//   result    found, read_value                     valid for one cycle on done
//   config    capacity                              written when capacity_we
//
// an item runs from start to done as two passes over the n entries held: one read
// pass over the entry memory finds the key and the oldest entry, a second
// read-modify-write pass ages the ranks and stores a put (a get miss writes nothing),
// one word per cycle, and each pass ends by draining its last read.
// reset empties the store and sets capacity to 16 (ENTRIES if smaller); no clearing pass is needed.
// the receiver cannot stall: done marks the word for exactly one cycle.
module lru_key_value_cache #(
    parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [KEY_BITS-1:0]            lookup_key,
    input  logic [VALUE_BITS-1:0]          write_value,
    output logic                           done,
    output logic                           found,
    output logic [lkvc_pkg::READ_BITS-1:0] read_value,
    input  logic                           capacity_we,
    input  logic [lkvc_pkg::CAP_BITS-1:0]  capacity
);

    import lkvc_pkg::*;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int VAL_LSB = IDX_W;
    localparam int KEY_LSB = IDX_W + VALUE_BITS;
    localparam int WORD_W  = KEY_BITS + VALUE_BITS + IDX_W;
    localparam int CAP_INIT = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic             done_reg, done_next;

    // item and scan results
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic                  kind_reg, kind_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] wval_reg, wval_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hslot_reg, hslot_next;
    logic [IDX_W-1:0]      hrank_reg, hrank_next;
    logic [VALUE_BITS-1:0] hval_reg, hval_next;
    logic [IDX_W-1:0]      vict_reg, vict_next;
    logic [IDX_W-1:0]      vrank_reg, vrank_next;
    logic                  vseen_reg, vseen_next;
    logic                  found_reg, found_next;
    logic [READ_BITS-1:0]  rval_reg, rval_next;

    // memory port
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_wa, mem_ra;
    logic [WORD_W-1:0] mem_wd, mem_rd;

    logic [KEY_BITS-1:0]   e_key, w_key;
    logic [VALUE_BITS-1:0] e_val, w_val;
    logic [IDX_W-1:0]      e_rank, w_rank;

    logic                  issue, ins, evict;
    logic [CNT_W-1:0]      cap_sat;
    logic [READ_BITS+VALUE_BITS-1:0] hval_wide;

    lkvc_entry_mem #(
        .DEPTH  (ENTRIES),
        .WIDTH  (WORD_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .re    (mem_re),
        .raddr (mem_ra),
        .rdata (mem_rd)
    );

    assign e_key  = mem_rd[KEY_LSB +: KEY_BITS];
    assign e_val  = mem_rd[VAL_LSB +: VALUE_BITS];
    assign e_rank = mem_rd[IDX_W-1:0];
    assign mem_wd = {w_key, w_val, w_rank};

    assign issue = (idx_reg < occ_reg);
    assign ins   = kind_reg && !hit_reg;
    assign evict = ins && (occ_reg >= cap_reg);
    assign hval_wide = {{READ_BITS{1'b0}}, hval_reg};

    // zero saturates to one, anything above the depth to the depth
    always_comb
    begin
        if (capacity == '0)
        begin
            cap_sat = CNT_W'(1);
        end
        else if (int'(capacity) > ENTRIES)
        begin
            cap_sat = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_sat = CNT_W'(capacity);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        occ_next   = occ_reg;
        cap_next   = cap_reg;
        done_next  = 1'b0;
        pidx_next  = pidx_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        wval_next  = wval_reg;
        hit_next   = hit_reg;
        hslot_next = hslot_reg;
        hrank_next = hrank_reg;
        hval_next  = hval_reg;
        vict_next  = vict_reg;
        vrank_next = vrank_reg;
        vseen_next = vseen_reg;
        found_next = found_reg;
        rval_next  = rval_reg;
        mem_re     = 1'b0;
        mem_ra     = idx_reg[IDX_W-1:0];
        mem_we     = 1'b0;
        mem_wa     = pidx_reg;
        w_key      = e_key;
        w_val      = e_val;
        w_rank     = e_rank;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    key_next   = lookup_key;
                    wval_next  = write_value;
                    hit_next   = 1'b0;
                    vseen_next = 1'b0;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (e_key == key_reg)
                    begin
                        hit_next   = 1'b1;
                        hslot_next = pidx_reg;
                        hrank_next = e_rank;
                        hval_next  = e_val;
                    end
                    if (!vseen_reg || (e_rank > vrank_reg))
                    begin
                        vseen_next = 1'b1;
                        vict_next  = pidx_reg;
                        vrank_next = e_rank;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_UPD;
                end
            end

            ST_UPD:
            begin
                if (issue)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // write back the word read last cycle; the read runs one address ahead
                if (pend_reg)
                begin
                    if (hit_reg)
                    begin
                        mem_we = 1'b1;
                        if (pidx_reg == hslot_reg)
                        begin
                            w_rank = '0;
                            if (kind_reg)
                            begin
                                w_val = wval_reg;
                            end
                        end
                        else if (e_rank < hrank_reg)
                        begin
                            w_rank = e_rank + IDX_W'(1);
                        end
                    end
                    else if (ins)
                    begin
                        mem_we = 1'b1;
                        if (evict && (pidx_reg == vict_reg))
                        begin
                            w_key  = key_reg;
                            w_val  = wval_reg;
                            w_rank = '0;
                        end
                        else
                        begin
                            w_rank = e_rank + IDX_W'(1);
                        end
                    end
                end
                if (!issue && !pend_reg)
                begin
                    // not full: the new word goes to the first free slot
                    if (ins && !evict)
                    begin
                        mem_we   = 1'b1;
                        mem_wa   = occ_reg[IDX_W-1:0];
                        w_key    = key_reg;
                        w_val    = wval_reg;
                        w_rank   = '0;
                        occ_next = occ_reg + CNT_W'(1);
                    end
                    done_next  = 1'b1;
                    found_next = hit_reg;
                    rval_next  = (!kind_reg && hit_reg) ? hval_wide[READ_BITS-1:0] : '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a capacity write empties the store at any edge
        if (capacity_we)
        begin
            cap_next = cap_sat;
            occ_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            occ_reg   <= '0;
            cap_reg   <= CNT_W'(CAP_INIT);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            occ_reg   <= occ_next;
            cap_reg   <= cap_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        wval_reg  <= wval_next;
        hit_reg   <= hit_next;
        hslot_reg <= hslot_next;
        hrank_reg <= hrank_next;
        hval_reg  <= hval_next;
        vict_reg  <= vict_next;
        vrank_reg <= vrank_next;
        vseen_reg <= vseen_next;
        found_reg <= found_next;
        rval_reg  <= rval_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = rval_reg;

endmodule

### rtl/lkvc_checker.sv
// lkvc_checker: port-level assertions for lru_key_value_cache, with its bind
// depends on lkvc_pkg
module lkvc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           found,
    input logic [lkvc_pkg::READ_BITS-1:0] read_value
);

    import lkvc_pkg::*;

    // an accepted word must raise busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    // the result leaves as the block goes idle
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // misses return zero (puts return zero as well, but this checks misses only)
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (read_value == '0))
        else $error("nonzero value on a miss");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for lru_key_value_cache, with a directed table then random
// get/put words over small key pools; a behavioral lru mirror predicts each untyped result
// depends on lkvc_pkg and the lru_key_value_cache rtl
module testbench;
    import lkvc_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int NUM_PHASES = 8;

    typedef enum logic { OP_GET = 1'b0, OP_PUT = 1'b1 } op_e;
    typedef enum logic [1:0] { STEP_GET, STEP_PUT, STEP_CAP } step_e;

    typedef struct packed {
        logic                 found;
        logic [READ_BITS-1:0] read_value;
    } lookup_result_t;

    typedef struct packed {
        step_e                     step;
        logic [DEF_KEY_BITS-1:0]   key;
        logic [DEF_VALUE_BITS-1:0] data;
        logic                      typed;
        logic                      exp_found;
        logic [READ_BITS-1:0]      exp_value;
    } stim_row_t;

    // typed rows carry their result; the rest are checked by the lru mirror
    localparam int NUM_ROWS = 24;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{STEP_GET, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_PUT, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h0000, 32'h1234_5678, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{STEP_PUT, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{STEP_PUT, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{STEP_GET, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{STEP_GET, 16'h1234, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_CAP, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_PUT, 16'hAAAA, 32'h5555_5555, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_PUT, 16'h5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'hAAAA, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h5555, 32'h0000_0000, 1'b1, 1'b1, 32'hAAAA_AAAA},
        '{STEP_CAP, 16'h0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h5555, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_CAP, 16'h0000, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
        '{STEP_PUT, 16'h0001, 32'h0000_0011, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_PUT, 16'h0002, 32'h0000_0022, 1'b1, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{STEP_PUT, 16'h0003, 32'h0000_0033, 1'b0, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{STEP_GET, 16'h0003, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
    };

    // capacity per random phase; 17 and 0 exercise the saturation
    localparam logic [CAP_BITS-1:0] PHASE_CAPS [NUM_PHASES] = '{
        5'd16, 5'd1, 5'd3, 5'd8, 5'd17, 5'd4, 5'd12, 5'd0
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      kind;
    logic [DEF_KEY_BITS-1:0]   lookup_key;
    logic [DEF_VALUE_BITS-1:0] write_value;
    logic                      done;
    logic                      found;
    logic [READ_BITS-1:0]      read_value;
    logic                      capacity_we;
    logic [CAP_BITS-1:0]       capacity;

    // lru mirror of the store
    logic [DEF_KEY_BITS-1:0]   mirror_key   [DEF_ENTRIES];
    logic [DEF_VALUE_BITS-1:0] mirror_value [DEF_ENTRIES];
    logic                      mirror_valid [DEF_ENTRIES];
    int unsigned               mirror_rank  [DEF_ENTRIES];
    int unsigned               mirror_count;
    int unsigned               mirror_cap;

    lookup_result_t pending_results [$];
    int unsigned    mismatches = 0;
    bit             idle_on = 1'b1;

    lru_key_value_cache u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .done        (done),
        .found       (found),
        .read_value  (read_value),
        .capacity_we (capacity_we),
        .capacity    (capacity)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("** lru_key_value_cache: FAILED **");
        $finish;
    end

    task automatic empty_mirror();
        for (int i = 0; i < DEF_ENTRIES; i++)
        begin
            mirror_valid[i] = 1'b0;
            mirror_rank[i]  = 0;
        end
        mirror_count = 0;
    endtask

    // make slot the most recent; newer entries age by one
    task automatic touch_slot(input int slot);
        int unsigned r;
        r = mirror_rank[slot];
        for (int i = 0; i < DEF_ENTRIES; i++)
            if (mirror_valid[i] && mirror_rank[i] < r)
                mirror_rank[i]++;
        mirror_rank[slot] = 0;
    endtask

    task automatic lru_access(input op_e op, input logic [DEF_KEY_BITS-1:0] key,
                              input logic [DEF_VALUE_BITS-1:0] data,
                              output lookup_result_t res);
        int hit;
        int victim;
        int slot;
        hit = -1;
        for (int i = 0; i < DEF_ENTRIES && hit < 0; i++)
            if (mirror_valid[i] && mirror_key[i] == key)
                hit = i;
        res.found      = (hit >= 0);
        res.read_value = '0;
        if (op == OP_GET)
        begin
            if (hit >= 0)
            begin
                res.read_value = mirror_value[hit];
                touch_slot(hit);
            end
        end
        else if (hit >= 0)
        begin
            mirror_value[hit] = data;
            touch_slot(hit);
        end
        else
        begin
            if (mirror_count >= mirror_cap)
            begin
                victim = -1;
                for (int i = 0; i < DEF_ENTRIES; i++)
                    if (mirror_valid[i] &&
                        (victim < 0 || mirror_rank[i] > mirror_rank[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    mirror_valid[victim] = 1'b0;
                    mirror_rank[victim]  = 0;
                    if (mirror_count > 0)
                        mirror_count--;
                end
            end
            slot = -1;
            for (int i = 0; i < DEF_ENTRIES && slot < 0; i++)
                if (!mirror_valid[i])
                    slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < DEF_ENTRIES; i++)
                    if (mirror_valid[i])
                        mirror_rank[i]++;
                mirror_key[slot]   = key;
                mirror_value[slot] = data;
                mirror_valid[slot] = 1'b1;
                mirror_rank[slot]  = 0;
                mirror_count++;
            end
        end
    endtask

    // present one command word and wait until the block takes it
    task automatic send_word(input op_e op, input logic [DEF_KEY_BITS-1:0] key,
                             input logic [DEF_VALUE_BITS-1:0] data,
                             input logic use_typed, input lookup_result_t typed_res);
        int gap;
        lookup_result_t res;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= op;
        lookup_key  <= key;
        write_value <= data;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        lru_access(op, key, data, res);
        pending_results = {pending_results, (use_typed ? typed_res : res)};
    endtask

    // drop start, let every result arrive and the block go quiet
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        capacity_we <= 1'b1;
        capacity    <= cap;
        @(posedge clk);
        capacity_we <= 1'b0;
        if (cap < 1)
            mirror_cap = 1;
        else if (cap > DEF_ENTRIES)
            mirror_cap = DEF_ENTRIES;
        else
            mirror_cap = int'(cap);
        empty_mirror();
    endtask

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: found=%0b read_value=%h",
                       found, read_value);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0b, actual %0b", want.found, found);
                    mismatches++;
                end
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, actual %h", want.read_value, read_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t                 row;
        lookup_result_t            typed_res;
        logic [DEF_KEY_BITS-1:0]   key_pool [32];
        int                        pool_size;
        logic [DEF_KEY_BITS-1:0]   key;
        op_e                       op;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = OP_GET;
        lookup_key  = '0;
        write_value = '0;
        capacity_we = 1'b0;
        capacity    = '0;
        mirror_cap  = CAP_RESET;
        empty_mirror();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            if (row.step == STEP_CAP)
            begin
                drain_results();
                set_capacity(row.data[CAP_BITS-1:0]);
            end
            else
            begin
                typed_res.found      = row.exp_found;
                typed_res.read_value = row.exp_value;
                send_word(row.step == STEP_PUT ? OP_PUT : OP_GET, row.key, row.data,
                          row.typed, typed_res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            set_capacity(PHASE_CAPS[p]);
            // pool a bit larger than the capacity so hits and evictions both happen
            pool_size = int'(mirror_cap + $urandom_range(1, mirror_cap + 2));
            if (pool_size > 32)
                pool_size = 32;
            for (int k = 0; k < pool_size; k++)
                key_pool[k] = DEF_KEY_BITS'($urandom_range(0, 16'hFFFF));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                if ($urandom_range(0, 9) == 0)
                    key = DEF_KEY_BITS'($urandom_range(0, 16'hFFFF));
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
                send_word(op, key, $urandom(), 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("** lru_key_value_cache: PASSED **");
        else
            $display("** lru_key_value_cache: FAILED **");
        $finish;
    end

endmodule
